// ===== rtl/core/fd_pkg.sv =====
// ----------------------------------------------------------------------------
// fd_pkg: shared types and constants of the fall detector
// Config struct, register indexes, arithmetic unit opcodes, posture band table.
// ----------------------------------------------------------------------------
package fd_pkg;

    localparam int DEF_AXIS_BITS = 16;
    localparam int DEF_TIME_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FF_THR     = 3'd0,
        CFG_FF_NEED    = 3'd1,
        CFG_IMP_WIN    = 3'd2,
        CFG_CONF_WIN   = 3'd3,
        CFG_IMP_THR    = 3'd4,
        CFG_HARD_IMP   = 3'd5,
        CFG_IMP_ROT    = 3'd6,
        CFG_STILL_NEED = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] ff_thr;
        logic [9:0]  ff_need;
        logic [15:0] imp_win;
        logic [15:0] conf_win;
        logic [15:0] imp_thr;
        logic [15:0] hard_imp;
        logic [15:0] imp_rot;
        logic [15:0] still_need;
    } t_cfg;

    localparam logic [11:0] RST_FF_THR     = 12'd650;
    localparam logic [9:0]  RST_FF_NEED    = 10'd40;
    localparam logic [15:0] RST_IMP_WIN    = 16'd800;
    localparam logic [15:0] RST_CONF_WIN   = 16'd8000;
    localparam logic [15:0] RST_IMP_THR    = 16'd1400;
    localparam logic [15:0] RST_HARD_IMP   = 16'd1800;
    localparam logic [15:0] RST_IMP_ROT    = 16'd700;
    localparam logic [15:0] RST_STILL_NEED = 16'd5000;

    typedef enum logic {
        ARITH_MUL  = 1'b0,
        ARITH_SQRT = 1'b1
    } t_arith_op;

    // fixed thresholds
    localparam logic [15:0] MAG_MID_IMP   = 16'd1200;
    localparam logic [15:0] ROT_MID_IMP   = 16'd350;
    localparam logic [15:0] BASE_MAG_LO   = 16'd750;
    localparam logic [15:0] BASE_MAG_HI   = 16'd1250;
    localparam logic [15:0] STILL_MAG_LO  = 16'd850;
    localparam logic [15:0] STILL_MAG_HI  = 16'd1150;
    localparam logic [15:0] STILL_ROT_MAX = 16'd110;
    localparam logic [15:0] PEAK_STRONG   = 16'd2200;
    localparam logic [15:0] ROT_MODERATE  = 16'd450;
    localparam logic [15:0] STILL_LONG    = 16'd1800;
    localparam logic [7:0]  DT_MIN        = 8'd20;
    localparam logic [7:0]  DT_MAX        = 8'd250;
    localparam logic [7:0]  POST_FLAG_DEG = 8'd30;
    localparam logic [7:0]  POST_MID_DEG  = 8'd45;
    localparam logic [7:0]  POST_BIG_DEG  = 8'd75;
    localparam logic [7:0]  POST_MAX_DEG  = 8'd165;
    localparam logic [6:0]  CONF_BASE     = 7'd58;
    localparam logic [6:0]  CONF_CAP      = 7'd96;
    localparam logic [6:0]  CONF_HIGH     = 7'd85;
    localparam logic [2:0]  RISK_FALL     = 3'd3;
    localparam logic [2:0]  RISK_HIGH     = 3'd4;
    localparam logic [10:0] COS_SCALE     = 11'd1000;
    localparam logic [3:0]  BAND_LAST     = 4'd9;
    localparam logic [3:0]  BAND_FIRST_STRICT = 4'd5;

    // Band i is hit when x >= k*d (positive limits) or x > k*d (limit <= 0,
    // k = limit - 1), x = 1000*dot, d = |b|*|a|. Same as trunc(x/d) >= limit.
    function automatic logic signed [11:0] band_mult(input logic [3:0] idx);
        logic signed [11:0] k;
        case (idx)
            4'd0:    k = 12'sd966;
            4'd1:    k = 12'sd866;
            4'd2:    k = 12'sd707;
            4'd3:    k = 12'sd500;
            4'd4:    k = 12'sd259;
            4'd5:    k = -12'sd1;
            4'd6:    k = -12'sd260;
            4'd7:    k = -12'sd501;
            4'd8:    k = -12'sd708;
            4'd9:    k = -12'sd867;
            default: k = 12'sd0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/fd_if.sv =====
// ----------------------------------------------------------------------------
// fd_if: channel interfaces of the fall detector
// Sample, result and config write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fd_sample_if #(
    parameter int AXIS_BITS = 16,
    parameter int TIME_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [TIME_BITS-1:0]        time_ms;
    logic signed [AXIS_BITS-1:0] accel_x;
    logic signed [AXIS_BITS-1:0] accel_y;
    logic signed [AXIS_BITS-1:0] accel_z;
    logic signed [AXIS_BITS-1:0] rate_x;
    logic signed [AXIS_BITS-1:0] rate_y;
    logic signed [AXIS_BITS-1:0] rate_z;

    modport source (output valid, time_ms, accel_x, accel_y, accel_z,
                    rate_x, rate_y, rate_z, input ready);
    modport sink   (input valid, time_ms, accel_x, accel_y, accel_z,
                    rate_x, rate_y, rate_z, output ready);
endinterface

interface fd_result_if;
    logic        valid;
    logic        ready;
    logic        detected;
    logic [2:0]  risk;
    logic [6:0]  confidence;
    logic [15:0] peak_accel;
    logic [15:0] peak_rotation;
    logic [7:0]  posture_angle;
    logic [15:0] still_time;

    modport source (output valid, detected, risk, confidence, peak_accel,
                    peak_rotation, posture_angle, still_time, input ready);
    modport sink   (input valid, detected, risk, confidence, peak_accel,
                    peak_rotation, posture_angle, still_time, output ready);
endinterface

interface fd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fd_cfg_regs: configuration register file
// Eight threshold/window registers, written one word per handshake.
// ----------------------------------------------------------------------------
module fd_cfg_regs import fd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fd_cfg_if.sink i_cfg,
    output t_cfg o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ff_thr     <= RST_FF_THR;
            r_cfg.ff_need    <= RST_FF_NEED;
            r_cfg.imp_win    <= RST_IMP_WIN;
            r_cfg.conf_win   <= RST_CONF_WIN;
            r_cfg.imp_thr    <= RST_IMP_THR;
            r_cfg.hard_imp   <= RST_HARD_IMP;
            r_cfg.imp_rot    <= RST_IMP_ROT;
            r_cfg.still_need <= RST_STILL_NEED;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FF_THR:     r_cfg.ff_thr     <= i_cfg.data[11:0];
                CFG_FF_NEED:    r_cfg.ff_need    <= i_cfg.data[9:0];
                CFG_IMP_WIN:    r_cfg.imp_win    <= i_cfg.data;
                CFG_CONF_WIN:   r_cfg.conf_win   <= i_cfg.data;
                CFG_IMP_THR:    r_cfg.imp_thr    <= i_cfg.data;
                CFG_HARD_IMP:   r_cfg.hard_imp   <= i_cfg.data;
                CFG_IMP_ROT:    r_cfg.imp_rot    <= i_cfg.data;
                CFG_STILL_NEED: r_cfg.still_need <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/fd_arith.sv =====
// ----------------------------------------------------------------------------
// fd_arith: shared iterative arithmetic unit
// Signed shift-add multiply (one multiplier bit per cycle) and bit-serial
// integer square root (one root bit per cycle).
// ----------------------------------------------------------------------------
module fd_arith import fd_pkg::*; #(
    parameter int AXIS_BITS = DEF_AXIS_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  t_arith_op                      i_op,
    input  logic signed [2*AXIS_BITS+11:0] i_a,
    input  logic signed [2*AXIS_BITS+11:0] i_b,
    output logic                           o_done,
    output logic signed [2*AXIS_BITS+11:0] o_result
);

    localparam int WW = 2*AXIS_BITS + 12;   // product width
    localparam int MB = AXIS_BITS + 2;      // multiplier bits walked
    localparam int SB = 2*AXIS_BITS;        // radicand bits
    localparam int RB = AXIS_BITS + 3;      // partial remainder bits
    localparam int CW = $clog2(MB + 1);

    logic                 r_busy;
    logic                 r_done;
    t_arith_op            r_op;
    logic [CW-1:0]        r_cnt;
    logic [WW-1:0]        r_mcand;
    logic [MB-1:0]        r_mplier;
    logic [WW-1:0]        r_acc;
    logic                 r_neg;
    logic [SB-1:0]        r_rad;
    logic [RB-1:0]        r_rem;
    logic [AXIS_BITS-1:0] r_root;

    logic [WW-1:0] abs_a;
    logic [WW-1:0] abs_b;
    logic [RB-1:0] rem_sh;
    logic [RB-1:0] trial;

    assign abs_a  = i_a[WW-1] ? WW'(-i_a) : WW'(i_a);
    assign abs_b  = i_b[WW-1] ? WW'(-i_b) : WW'(i_b);
    assign rem_sh = {r_rem[RB-3:0], r_rad[SB-1:SB-2]};
    assign trial  = RB'({r_root, 2'b01});

    assign o_done   = r_done;
    assign o_result = (r_op == ARITH_MUL) ? (r_neg ? -$signed(r_acc) : $signed(r_acc))
                                          : $signed(WW'(r_root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ARITH_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                if (i_op == ARITH_MUL) begin
                    r_cnt <= CW'(MB);
                end else begin
                    r_cnt <= CW'(AXIS_BITS);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_mcand  <= abs_a;
            r_mplier <= abs_b[MB-1:0];
            r_acc    <= '0;
            r_neg    <= i_a[WW-1] ^ i_b[WW-1];
            r_rad    <= i_a[SB-1:0];
            r_rem    <= '0;
            r_root   <= '0;
        end else if (r_busy) begin
            if (r_op == ARITH_MUL) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end else begin
                r_rad <= r_rad << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[AXIS_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[AXIS_BITS-2:0], 1'b0};
                end
            end
        end
    end

endmodule

// ===== rtl/core/imu_fall_detector_core.sv =====
// ----------------------------------------------------------------------------
// imu_fall_detector_core: rule-based fall detector on IMU samples
// Magnitudes, free-fall / impact / confirm phases, gravity baseline, posture
// bands and confidence scoring, all sequenced over one shared arithmetic unit.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake    | word
//  i_sample  | in  | valid/ready  | time_ms, accel_x/y/z, rate_x/y/z
//  o_result  | out | valid/ready  | detected, risk, confidence, peaks, posture,
//            |     |              | still_time (one word per sample)
//  i_cfg     | in  | valid/ready  | index, data (ready always high)
//
//  One sample at a time; every multiply and root runs in the shared unit. The
//  impact phase with a baseline adds a dot product, a baseline norm and up
//  to ten band compares, each compare one multiply.
//  Sync active-low reset clears all detector state; no clearing pass.
//  A result held by a stalled o_result blocks only the end of the next sample.
// ----------------------------------------------------------------------------
module imu_fall_detector_core import fd_pkg::*; #(
    parameter int AXIS_BITS = DEF_AXIS_BITS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fd_sample_if.sink   i_sample,
    fd_result_if.source o_result,
    fd_cfg_if.sink      i_cfg
);

    localparam int WW = 2*AXIS_BITS + 12;

    // sequencer
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ISSUE  = 5'b00010,
        S_WAIT   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_FINISH = 5'b10000
    } t_fsm;

    // arithmetic steps
    typedef enum logic [4:0] {
        ST_AX2, ST_AY2, ST_AZ2, ST_SQA,
        ST_GX2, ST_GY2, ST_GZ2, ST_SQG,
        ST_DOT0, ST_DOT1, ST_DOT2,
        ST_BB0, ST_BB1, ST_BB2, ST_SQB,
        ST_XS, ST_DEN, ST_THR
    } t_step;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_FREEFALL = 3'b010,
        PH_IMPACT   = 3'b100
    } t_phase;

    t_cfg cfg;

    t_fsm  r_fsm, n_fsm;
    t_step r_step, n_step;

    // detector state
    t_phase               r_phase, n_phase;
    logic [15:0]          r_ff_acc, n_ff_acc;
    logic [TIME_BITS-1:0] r_ff_start, n_ff_start;
    logic [TIME_BITS-1:0] r_imp_time, n_imp_time;
    logic [TIME_BITS-1:0] r_prev_time, n_prev_time;
    logic                 r_prev_valid, n_prev_valid;
    logic [15:0]          r_peak_mag, n_peak_mag;
    logic [15:0]          r_peak_rot, n_peak_rot;
    logic [7:0]           r_max_post, n_max_post;
    logic [15:0]          r_still, n_still;
    logic                 r_post_flag, n_post_flag;
    logic                 r_base_ok, n_base_ok;
    logic signed [AXIS_BITS-1:0] r_base [3];
    logic signed [AXIS_BITS-1:0] n_base [3];

    // per-sample working registers
    logic [TIME_BITS-1:0]        r_t;
    logic signed [AXIS_BITS-1:0] r_av [3];
    logic signed [AXIS_BITS-1:0] r_gv [3];
    logic [AXIS_BITS-1:0]        r_amag, n_amag;
    logic [AXIS_BITS-1:0]        r_rot_full, n_rot_full;
    logic [AXIS_BITS-1:0]        r_bm, n_bm;
    logic [7:0]                  r_dt, n_dt;
    logic signed [WW-1:0]        r_acc, n_acc;
    logic signed [WW-1:0]        r_dot, n_dot;
    logic [3:0]                  r_band, n_band;
    logic [7:0]                  r_deg, n_deg;
    logic                        r_post, n_post;

    // result register
    logic        r_out_valid, n_out_valid;
    logic        r_det, n_det;
    logic [2:0]  r_risk, n_risk;
    logic [6:0]  r_conf, n_conf;
    logic [15:0] r_o_peak_mag, n_o_peak_mag;
    logic [15:0] r_o_peak_rot, n_o_peak_rot;
    logic [7:0]  r_o_post, n_o_post;
    logic [15:0] r_o_still, n_o_still;

    // arithmetic unit
    logic                 au_start;
    t_arith_op            au_op;
    logic signed [WW-1:0] au_a;
    logic signed [WW-1:0] au_b;
    logic                 au_done;
    logic signed [WW-1:0] au_res;

    logic in_take;

    fd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fd_arith #(.AXIS_BITS(AXIS_BITS)) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (au_start),
        .i_op     (au_op),
        .i_a      (au_a),
        .i_b      (au_b),
        .o_done   (au_done),
        .o_result (au_res)
    );

    function automatic logic [15:0] sat16(input logic [AXIS_BITS-1:0] v);
        logic [AXIS_BITS+16:0] w;
        w = (AXIS_BITS+17)'(v);
        return (w > (AXIS_BITS+17)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [15:0] add_sat(input logic [15:0] a, input logic [7:0] b);
        logic [16:0] s;
        s = 17'(a) + 17'(b);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    assign i_sample.ready = (r_fsm == S_IDLE);
    assign in_take        = i_sample.valid && (r_fsm == S_IDLE);
    assign au_start       = (r_fsm == S_ISSUE);

    assign o_result.valid         = r_out_valid;
    assign o_result.detected      = r_det;
    assign o_result.risk          = r_risk;
    assign o_result.confidence    = r_conf;
    assign o_result.peak_accel    = r_o_peak_mag;
    assign o_result.peak_rotation = r_o_peak_rot;
    assign o_result.posture_angle = r_o_post;
    assign o_result.still_time    = r_o_still;

    // operand select per step
    always_comb begin
        au_op = ARITH_MUL;
        au_a  = '0;
        au_b  = '0;
        case (r_step)
            ST_AX2:  begin au_a = WW'(r_av[0]); au_b = WW'(r_av[0]); end
            ST_AY2:  begin au_a = WW'(r_av[1]); au_b = WW'(r_av[1]); end
            ST_AZ2:  begin au_a = WW'(r_av[2]); au_b = WW'(r_av[2]); end
            ST_GX2:  begin au_a = WW'(r_gv[0]); au_b = WW'(r_gv[0]); end
            ST_GY2:  begin au_a = WW'(r_gv[1]); au_b = WW'(r_gv[1]); end
            ST_GZ2:  begin au_a = WW'(r_gv[2]); au_b = WW'(r_gv[2]); end
            ST_DOT0: begin au_a = WW'(r_base[0]); au_b = WW'(r_av[0]); end
            ST_DOT1: begin au_a = WW'(r_base[1]); au_b = WW'(r_av[1]); end
            ST_DOT2: begin au_a = WW'(r_base[2]); au_b = WW'(r_av[2]); end
            ST_BB0:  begin au_a = WW'(r_base[0]); au_b = WW'(r_base[0]); end
            ST_BB1:  begin au_a = WW'(r_base[1]); au_b = WW'(r_base[1]); end
            ST_BB2:  begin au_a = WW'(r_base[2]); au_b = WW'(r_base[2]); end
            ST_SQA, ST_SQG, ST_SQB: begin
                au_op = ARITH_SQRT;
                au_a  = r_acc;
            end
            ST_XS:   begin au_a = r_dot; au_b = $signed(WW'(COS_SCALE)); end
            ST_DEN:  begin au_a = $signed(WW'(r_bm)); au_b = $signed(WW'(r_amag)); end
            ST_THR:  begin au_a = r_acc; au_b = WW'(band_mult(r_band)); end
            default: ;
        endcase
    end

    // sequencer and detector update
    always_comb begin
        logic [15:0]          mag;
        logic [15:0]          rot;
        logic [TIME_BITS-1:0] diff;
        logic [TIME_BITS-1:0] el;
        logic [7:0]           dt;
        logic                 clr;
        logic                 hit;
        logic [7:0]           mp;
        logic                 pf;
        logic [15:0]          st;
        logic [6:0]           conf;
        logic signed [AXIS_BITS+3:0] bx;
        logic signed [AXIS_BITS+3:0] sx;

        n_fsm        = r_fsm;
        n_step       = r_step;
        n_phase      = r_phase;
        n_ff_acc     = r_ff_acc;
        n_ff_start   = r_ff_start;
        n_imp_time   = r_imp_time;
        n_prev_time  = r_prev_time;
        n_prev_valid = r_prev_valid;
        n_peak_mag   = r_peak_mag;
        n_peak_rot   = r_peak_rot;
        n_max_post   = r_max_post;
        n_still      = r_still;
        n_post_flag  = r_post_flag;
        n_base_ok    = r_base_ok;
        n_base       = r_base;
        n_amag       = r_amag;
        n_rot_full   = r_rot_full;
        n_bm         = r_bm;
        n_dt         = r_dt;
        n_acc        = r_acc;
        n_dot        = r_dot;
        n_band       = r_band;
        n_deg        = r_deg;
        n_post       = r_post;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_det        = r_det;
        n_risk       = r_risk;
        n_conf       = r_conf;
        n_o_peak_mag = r_o_peak_mag;
        n_o_peak_rot = r_o_peak_rot;
        n_o_post     = r_o_post;
        n_o_still    = r_o_still;

        mag  = sat16(r_amag);
        rot  = sat16(r_rot_full);
        diff = r_t - r_prev_time;
        el   = '0;
        dt   = DT_MIN;
        clr  = 1'b0;
        hit  = 1'b0;
        mp   = r_max_post;
        pf   = r_post_flag;
        st   = r_still;
        conf = CONF_BASE;
        bx   = '0;
        sx   = '0;

        case (r_fsm)
            S_IDLE: begin
                if (in_take) begin
                    n_step = ST_AX2;
                    n_fsm  = S_ISSUE;
                end
            end

            S_ISSUE: n_fsm = S_WAIT;

            S_WAIT: begin
                if (au_done) begin
                    n_fsm = S_ISSUE;
                    case (r_step)
                        ST_AX2:  begin n_acc = au_res;         n_step = ST_AY2; end
                        ST_AY2:  begin n_acc = r_acc + au_res; n_step = ST_AZ2; end
                        ST_AZ2:  begin n_acc = r_acc + au_res; n_step = ST_SQA; end
                        ST_SQA:  begin
                            n_amag = au_res[AXIS_BITS-1:0];
                            n_step = ST_GX2;
                        end
                        ST_GX2:  begin n_acc = au_res;         n_step = ST_GY2; end
                        ST_GY2:  begin n_acc = r_acc + au_res; n_step = ST_GZ2; end
                        ST_GZ2:  begin n_acc = r_acc + au_res; n_step = ST_SQG; end
                        ST_SQG:  begin
                            n_rot_full = au_res[AXIS_BITS-1:0];
                            n_fsm      = S_DECIDE;
                        end
                        ST_DOT0: begin n_dot = au_res;         n_step = ST_DOT1; end
                        ST_DOT1: begin n_dot = r_dot + au_res; n_step = ST_DOT2; end
                        ST_DOT2: begin n_dot = r_dot + au_res; n_step = ST_BB0; end
                        ST_BB0:  begin n_acc = au_res;         n_step = ST_BB1; end
                        ST_BB1:  begin n_acc = r_acc + au_res; n_step = ST_BB2; end
                        ST_BB2:  begin n_acc = r_acc + au_res; n_step = ST_SQB; end
                        ST_SQB:  begin
                            n_bm = au_res[AXIS_BITS-1:0];
                            // zero baseline or zero sample gives no posture
                            if (au_res == '0 || r_amag == '0) begin
                                n_deg = '0;
                                n_fsm = S_FINISH;
                            end else begin
                                n_step = ST_XS;
                            end
                        end
                        ST_XS:   begin n_dot = au_res; n_step = ST_DEN; end
                        ST_DEN:  begin
                            n_acc  = au_res;
                            n_band = '0;
                            n_step = ST_THR;
                        end
                        ST_THR:  begin
                            hit = (r_band >= BAND_FIRST_STRICT) ? (r_dot > au_res)
                                                                : (r_dot >= au_res);
                            if (hit) begin
                                n_deg = 8'(5'd15 * (5'(r_band) + 5'd1));
                                n_fsm = S_FINISH;
                            end else if (r_band == BAND_LAST) begin
                                n_deg = POST_MAX_DEG;
                                n_fsm = S_FINISH;
                            end else begin
                                n_band = r_band + 1'b1;
                            end
                        end
                        default: n_fsm = S_IDLE;
                    endcase
                end
            end

            S_DECIDE: begin
                // interval, clamped; first sample or non-increasing time is 20
                if (r_prev_valid && r_t > r_prev_time) begin
                    if (diff < TIME_BITS'(DT_MIN)) begin
                        dt = DT_MIN;
                    end else if (diff > TIME_BITS'(DT_MAX)) begin
                        dt = DT_MAX;
                    end else begin
                        dt = diff[7:0];
                    end
                end
                n_dt         = dt;
                n_prev_time  = r_t;
                n_prev_valid = 1'b1;
                n_post       = 1'b0;
                n_fsm        = S_FINISH;

                case (r_phase)
                    PH_IDLE: begin
                        if (mag >= BASE_MAG_LO && mag <= BASE_MAG_HI &&
                            rot <= STILL_ROT_MAX) begin
                            n_base_ok = 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                if (!r_base_ok) begin
                                    n_base[i] = r_av[i];
                                end else begin
                                    bx = (AXIS_BITS+4)'(r_base[i]);
                                    sx = (bx <<< 3) - bx + (AXIS_BITS+4)'(r_av[i]);
                                    if (sx < 0) begin
                                        sx = sx + (AXIS_BITS+4)'(7);
                                    end
                                    sx = sx >>> 3;
                                    n_base[i] = sx[AXIS_BITS-1:0];
                                end
                            end
                        end
                        if (mag < 16'(cfg.ff_thr)) begin
                            if (r_ff_acc == '0) begin
                                n_ff_start = r_t;
                            end
                            n_ff_acc = add_sat(r_ff_acc, dt);
                            if (n_ff_acc >= 16'(cfg.ff_need)) begin
                                n_phase     = PH_FREEFALL;
                                n_imp_time  = '0;
                                n_peak_mag  = mag;
                                n_peak_rot  = rot;
                                n_max_post  = '0;
                                n_still     = '0;
                                n_post_flag = 1'b0;
                            end
                        end else begin
                            n_ff_acc   = '0;
                            n_ff_start = '0;
                        end
                        if ((mag >= cfg.hard_imp && rot >= ROT_MID_IMP) ||
                            (mag >= cfg.imp_thr && rot >= cfg.imp_rot) ||
                            (mag >= MAG_MID_IMP && rot >= ROT_MID_IMP)) begin
                            n_phase     = PH_IMPACT;
                            n_imp_time  = r_t;
                            n_peak_mag  = mag;
                            n_peak_rot  = rot;
                            n_max_post  = '0;
                            n_still     = '0;
                            n_post_flag = 1'b0;
                        end
                    end

                    PH_FREEFALL: begin
                        el = r_t - r_ff_start;
                        if (el > TIME_BITS'(cfg.imp_win)) begin
                            clr = 1'b1;
                        end else if (mag < 16'(cfg.ff_thr)) begin
                            n_ff_acc = add_sat(r_ff_acc, dt);
                        end else if (mag >= cfg.imp_thr || rot >= cfg.imp_rot ||
                                     (mag >= MAG_MID_IMP && rot >= ROT_MID_IMP)) begin
                            n_phase     = PH_IMPACT;
                            n_imp_time  = r_t;
                            n_peak_mag  = mag;
                            n_peak_rot  = rot;
                            n_max_post  = '0;
                            n_still     = '0;
                            n_post_flag = 1'b0;
                        end
                    end

                    default: begin
                        // impact phase: clear on window timeout, else track peaks, then posture
                        el = r_t - r_imp_time;
                        if (el > TIME_BITS'(cfg.conf_win)) begin
                            clr = 1'b1;
                        end else begin
                            if (mag > r_peak_mag) n_peak_mag = mag;
                            if (rot > r_peak_rot) n_peak_rot = rot;
                            n_post = 1'b1;
                            if (r_base_ok) begin
                                n_step = ST_DOT0;
                                n_fsm  = S_ISSUE;
                            end else begin
                                n_deg = '0;
                            end
                        end
                    end
                endcase
            end

            S_FINISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_det        = 1'b0;
                    n_risk       = '0;
                    n_conf       = '0;
                    n_o_peak_mag = '0;
                    n_o_peak_rot = '0;
                    n_o_post     = '0;
                    n_o_still    = '0;
                    n_fsm        = S_IDLE;
                    if (r_post) begin
                        mp = (r_deg > r_max_post) ? r_deg : r_max_post;
                        pf = r_post_flag || (mp >= POST_FLAG_DEG);
                        if (pf && mag >= STILL_MAG_LO && mag <= STILL_MAG_HI &&
                            rot <= STILL_ROT_MAX) begin
                            st = add_sat(r_still, r_dt);
                        end else begin
                            st = '0;
                        end
                        n_max_post  = mp;
                        n_post_flag = pf;
                        n_still     = st;
                        if (pf && st >= cfg.still_need) begin
                            if (r_peak_mag >= PEAK_STRONG) begin
                                conf = conf + 7'd12;
                            end else if (r_peak_mag >= cfg.imp_thr) begin
                                conf = conf + 7'd8;
                            end
                            if (r_peak_rot >= cfg.imp_rot) begin
                                conf = conf + 7'd10;
                            end else if (r_peak_rot >= ROT_MODERATE) begin
                                conf = conf + 7'd7;
                            end
                            if (mp >= POST_BIG_DEG) begin
                                conf = conf + 7'd12;
                            end else if (mp >= POST_MID_DEG) begin
                                conf = conf + 7'd9;
                            end else if (mp >= POST_FLAG_DEG) begin
                                conf = conf + 7'd6;
                            end
                            if (st >= STILL_LONG) begin
                                conf = conf + 7'd10;
                            end else begin
                                conf = conf + 7'd7;
                            end
                            if (r_ff_acc >= 16'(cfg.ff_need)) begin
                                conf = conf + 7'd4;
                            end
                            if (conf > CONF_CAP) begin
                                conf = CONF_CAP;
                            end
                            n_det        = 1'b1;
                            n_risk       = (conf >= CONF_HIGH) ? RISK_HIGH : RISK_FALL;
                            n_conf       = conf;
                            n_o_peak_mag = r_peak_mag;
                            n_o_peak_rot = r_peak_rot;
                            n_o_post     = mp;
                            n_o_still    = st;
                            clr          = 1'b1;
                        end
                    end
                end
            end

            default: n_fsm = S_IDLE;
        endcase

        // back to reset state on timeout or confirmation
        if (clr) begin
            n_phase      = PH_IDLE;
            n_ff_acc     = '0;
            n_ff_start   = '0;
            n_imp_time   = '0;
            n_prev_time  = '0;
            n_prev_valid = 1'b0;
            n_peak_mag   = '0;
            n_peak_rot   = '0;
            n_max_post   = '0;
            n_still      = '0;
            n_post_flag  = 1'b0;
            n_base_ok    = 1'b0;
            for (int i = 0; i < 3; i++) begin
                n_base[i] = '0;
            end
        end
    end

    // control and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= S_IDLE;
            r_step       <= ST_AX2;
            r_phase      <= PH_IDLE;
            r_ff_acc     <= '0;
            r_ff_start   <= '0;
            r_imp_time   <= '0;
            r_prev_time  <= '0;
            r_prev_valid <= 1'b0;
            r_peak_mag   <= '0;
            r_peak_rot   <= '0;
            r_max_post   <= '0;
            r_still      <= '0;
            r_post_flag  <= 1'b0;
            r_base_ok    <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_base[i] <= '0;
            end
        end else begin
            r_fsm        <= n_fsm;
            r_step       <= n_step;
            r_phase      <= n_phase;
            r_ff_acc     <= n_ff_acc;
            r_ff_start   <= n_ff_start;
            r_imp_time   <= n_imp_time;
            r_prev_time  <= n_prev_time;
            r_prev_valid <= n_prev_valid;
            r_peak_mag   <= n_peak_mag;
            r_peak_rot   <= n_peak_rot;
            r_max_post   <= n_max_post;
            r_still      <= n_still;
            r_post_flag  <= n_post_flag;
            r_base_ok    <= n_base_ok;
            r_out_valid  <= n_out_valid;
            r_base       <= n_base;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_t     <= i_sample.time_ms;
            r_av[0] <= i_sample.accel_x;
            r_av[1] <= i_sample.accel_y;
            r_av[2] <= i_sample.accel_z;
            r_gv[0] <= i_sample.rate_x;
            r_gv[1] <= i_sample.rate_y;
            r_gv[2] <= i_sample.rate_z;
        end
        r_amag       <= n_amag;
        r_rot_full   <= n_rot_full;
        r_bm         <= n_bm;
        r_dt         <= n_dt;
        r_acc        <= n_acc;
        r_dot        <= n_dot;
        r_band       <= n_band;
        r_deg        <= n_deg;
        r_post       <= n_post;
        r_det        <= n_det;
        r_risk       <= n_risk;
        r_conf       <= n_conf;
        r_o_peak_mag <= n_o_peak_mag;
        r_o_peak_rot <= n_o_peak_rot;
        r_o_post     <= n_o_post;
        r_o_still    <= n_o_still;
    end

endmodule
